>>> hw/rtl/ircrq_pkg.sv
`default_nettype none
package ircrq_pkg;

  localparam int IDX_W = 3;
  localparam int CMD_W = 32;
  localparam int PROTO_W = 8;
  localparam int TIME_W = 32;
  localparam int CFG_MS_W = 16;

  localparam logic [TIME_W-1:0] NEC_REPEAT_WINDOW_MS = 32'd300;

  localparam logic [CFG_MS_W-1:0] GAP_RESET = 16'd150;
  localparam logic [CFG_MS_W-1:0] DELAY_RESET = 16'd500;
  localparam logic [PROTO_W-1:0] NEC_ID_RESET = 8'd1;
  localparam logic [CMD_W-1:0] NEC_CODE_RESET = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_COMMAND_GAP_MS = 2'd0,
    CFG_REPEAT_DELAY_MS = 2'd1,
    CFG_NEC_PROTOCOL_ID = 2'd2,
    CFG_NEC_REPEAT_CODE = 2'd3
  } cfg_reg_e_t;

  typedef enum logic {
    OP_CODE = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    logic op;
    logic [PROTO_W-1:0] protocol;
    logic [CMD_W-1:0] code;
    logic [TIME_W-1:0] time_ms;
    logic [IDX_W-1:0] entry_index;
    logic entry_repeatable;
  } in_item_t;

  typedef struct packed {
    logic accepted;
    logic is_repeat;
    logic [CMD_W-1:0] command;
    logic matched;
    logic [IDX_W-1:0] match_index;
    logic fire;
  } out_item_t;

  // token walking the entry chain
  typedef struct packed {
    logic vld;
    logic wr;
    logic [IDX_W-1:0] idx;
    logic rep_bit;
    logic look;
    logic [CMD_W-1:0] cmd;
    logic hit;
    logic [IDX_W-1:0] hit_idx;
    logic hit_rep;
  } probe_t;

endpackage
`default_nettype wire

>>> hw/rtl/ircrq_cell.sv
`default_nettype none
module ircrq_cell #(
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ircrq_pkg::probe_t probe_i,
  output ircrq_pkg::probe_t      probe_o
);

  localparam logic [ircrq_pkg::IDX_W-1:0] HIT_IDX = IDX[ircrq_pkg::IDX_W-1:0];

  logic [ircrq_pkg::CMD_W-1:0] cmd_r;
  logic                        rep_r;
  logic                        valid_r;
  ircrq_pkg::probe_t           probe_r;
  ircrq_pkg::probe_t           probe_nxt;
  logic                        wr_hit;
  logic                        lk_hit;

  always_comb begin
    wr_hit = probe_i.vld && probe_i.wr && (int'(probe_i.idx) == IDX);
    lk_hit = probe_i.vld && !probe_i.wr && probe_i.look && !probe_i.hit &&
             valid_r && (cmd_r == probe_i.cmd);
    probe_nxt = probe_i;
    if (lk_hit) begin
      probe_nxt.hit = 1'b1;
      probe_nxt.hit_idx = HIT_IDX;
      probe_nxt.hit_rep = rep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      probe_r.vld <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
      if (wr_hit) begin
        valid_r <= 1'b1;
        cmd_r <= probe_i.cmd;
        rep_r <= probe_i.rep_bit;
      end
    end
  end

  assign probe_o = probe_r;

endmodule
`default_nettype wire

>>> hw/rtl/ir_command_repeat_qualifier_core.sv
// Qualifies decoded infrared remote codes (fresh command, NEC repeat mapping,
// repeat delay) and looks the resulting command up in a table of
// TABLE_ENTRIES command entries; table writes use the same input channel.
// One item is in work at a time: it is qualified, then a lookup token walks
// the chain of entry cells one cell per cycle, and the registered result is
// held until taken; the next item is taken only after the result is taken.
// Configuration writes are taken at any time, one per cycle.
`default_nettype none
module ir_command_repeat_qualifier_core #(
  parameter int TABLE_ENTRIES = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire ircrq_pkg::in_item_t    in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output ircrq_pkg::out_item_t        out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [31:0]            cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUAL,
    ST_LAUNCH,
    ST_WAIT,
    ST_SEND
  } state_t;

  state_t state_r;

  logic [ircrq_pkg::CFG_MS_W-1:0] gap_r;
  logic [ircrq_pkg::CFG_MS_W-1:0] delay_r;
  logic [ircrq_pkg::PROTO_W-1:0]  nec_id_r;
  logic [ircrq_pkg::CMD_W-1:0]    nec_code_r;

  logic [ircrq_pkg::CMD_W-1:0]    last_cmd_r;
  logic [ircrq_pkg::PROTO_W-1:0]  last_proto_r;
  logic [ircrq_pkg::TIME_W-1:0]   last_rx_r;
  logic [ircrq_pkg::TIME_W-1:0]   last_fresh_r;

  ircrq_pkg::in_item_t            item_r;
  logic                           acc_r;
  logic                           rep_r;
  logic [ircrq_pkg::CMD_W-1:0]    cmd_r;
  ircrq_pkg::out_item_t           out_r;
  logic                           out_valid_r;

  logic [ircrq_pkg::TIME_W-1:0]   dt;
  logic [ircrq_pkg::TIME_W-1:0]   dt_fresh;
  logic                           is_code;
  logic                           fresh;
  logic                           mapped;
  logic                           acc_nxt;
  logic                           rep_nxt;
  logic [ircrq_pkg::CMD_W-1:0]    cmd_nxt;

  ircrq_pkg::probe_t              head;
  ircrq_pkg::probe_t              chain [0:TABLE_ENTRIES];
  ircrq_pkg::probe_t              tail;

  always_comb begin
    is_code = (item_r.op == ircrq_pkg::OP_CODE) && (item_r.protocol != '0);
    dt = item_r.time_ms - last_rx_r;
    dt_fresh = item_r.time_ms - last_fresh_r;
    fresh = dt > {{(ircrq_pkg::TIME_W-ircrq_pkg::CFG_MS_W){1'b0}}, gap_r};
    mapped = (item_r.protocol == nec_id_r) && (last_proto_r == nec_id_r) &&
             (item_r.code == nec_code_r) && (dt < ircrq_pkg::NEC_REPEAT_WINDOW_MS);
    cmd_nxt = (!fresh && mapped) ? last_cmd_r : item_r.code;
    acc_nxt = is_code && (fresh ||
              (dt_fresh > {{(ircrq_pkg::TIME_W-ircrq_pkg::CFG_MS_W){1'b0}}, delay_r}));
    rep_nxt = acc_nxt && !fresh &&
              (mapped || ((item_r.protocol == last_proto_r) && (cmd_nxt == last_cmd_r)));
    if (!is_code) begin
      cmd_nxt = '0;
    end
  end

  always_comb begin
    head.vld = (state_r == ST_LAUNCH);
    head.wr = (item_r.op == ircrq_pkg::OP_WRITE);
    head.idx = item_r.entry_index;
    head.rep_bit = item_r.entry_repeatable;
    head.look = acc_r;
    head.cmd = (item_r.op == ircrq_pkg::OP_WRITE) ? item_r.code : cmd_r;
    head.hit = 1'b0;
    head.hit_idx = '0;
    head.hit_rep = 1'b0;
  end

  assign chain[0] = head;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    ircrq_cell #(
      .IDX(g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .probe_i(chain[g]),
      .probe_o(chain[g+1])
    );
  end

  assign tail = chain[TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      gap_r <= ircrq_pkg::GAP_RESET;
      delay_r <= ircrq_pkg::DELAY_RESET;
      nec_id_r <= ircrq_pkg::NEC_ID_RESET;
      nec_code_r <= ircrq_pkg::NEC_CODE_RESET;
      last_cmd_r <= '0;
      last_proto_r <= '0;
      last_rx_r <= '0;
      last_fresh_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (ircrq_pkg::cfg_reg_e_t'(cfg_index))
          ircrq_pkg::CFG_COMMAND_GAP_MS:  gap_r <= cfg_data[ircrq_pkg::CFG_MS_W-1:0];
          ircrq_pkg::CFG_REPEAT_DELAY_MS: delay_r <= cfg_data[ircrq_pkg::CFG_MS_W-1:0];
          ircrq_pkg::CFG_NEC_PROTOCOL_ID: nec_id_r <= cfg_data[ircrq_pkg::PROTO_W-1:0];
          ircrq_pkg::CFG_NEC_REPEAT_CODE: nec_code_r <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            state_r <= ST_QUAL;
          end
        end
        ST_QUAL: begin
          acc_r <= acc_nxt;
          rep_r <= rep_nxt;
          cmd_r <= cmd_nxt;
          if (is_code) begin
            last_rx_r <= item_r.time_ms;
            if (fresh) begin
              last_cmd_r <= item_r.code;
              last_proto_r <= item_r.protocol;
              last_fresh_r <= item_r.time_ms;
            end
          end
          state_r <= ST_LAUNCH;
        end
        ST_LAUNCH: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (tail.vld) begin
            out_r.accepted <= acc_r;
            out_r.is_repeat <= rep_r;
            out_r.command <= cmd_r;
            out_r.matched <= tail.hit;
            out_r.match_index <= tail.hit_idx;
            out_r.fire <= tail.hit && (!rep_r || tail.hit_rep);
            out_valid_r <= 1'b1;
            state_r <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

>>> hw/rtl/ircrq_checker.sv
`default_nettype none
module ircrq_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire ircrq_pkg::out_item_t out_data
);

  // one item in work: no new item straight after acceptance
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  a_no_input_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input open while a result waits");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |->
      !out_data.is_repeat && !out_data.matched && !out_data.fire &&
      (out_data.match_index == '0))
    else $error("rejected code carries match fields");

  a_fire_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fire |-> out_data.matched && out_data.accepted)
    else $error("fire without a match");

endmodule

bind ir_command_repeat_qualifier_core ircrq_checker u_ircrq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import ircrq_pkg::*;

  localparam int TABLE_SIZE = 8;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS = 185;
  localparam int unsigned CYCLE_LIMIT = 500_000;

  class remote_command_judge;
    logic [CFG_MS_W-1:0] gap_ms;
    logic [CFG_MS_W-1:0] delay_ms;
    logic [PROTO_W-1:0] nec_id;
    logic [CMD_W-1:0] nec_code;
    logic [CMD_W-1:0] last_cmd;
    logic [PROTO_W-1:0] last_proto;
    logic [TIME_W-1:0] last_rx;
    logic [TIME_W-1:0] last_fresh;
    logic [CMD_W-1:0] tbl_cmd[TABLE_SIZE];
    bit tbl_rep[TABLE_SIZE];
    bit tbl_vld[TABLE_SIZE];
    out_item_t awaited[$];
    int bad_verdicts;

    function new();
      gap_ms = GAP_RESET;
      delay_ms = DELAY_RESET;
      nec_id = NEC_ID_RESET;
      nec_code = NEC_CODE_RESET;
      last_cmd = '0;
      last_proto = '0;
      last_rx = '0;
      last_fresh = '0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        tbl_cmd[i] = '0;
        tbl_rep[i] = 1'b0;
        tbl_vld[i] = 1'b0;
      end
      bad_verdicts = 0;
    endfunction

    function void set_reg(cfg_reg_e_t r, logic [31:0] d);
      case (r)
        CFG_COMMAND_GAP_MS: gap_ms = d[CFG_MS_W-1:0];
        CFG_REPEAT_DELAY_MS: delay_ms = d[CFG_MS_W-1:0];
        CFG_NEC_PROTOCOL_ID: nec_id = d[PROTO_W-1:0];
        CFG_NEC_REPEAT_CODE: nec_code = d[CMD_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_item(in_item_t it);
      out_item_t v;
      logic [TIME_W-1:0] dt;
      logic [TIME_W-1:0] since_fresh;
      logic [CMD_W-1:0] cmd;
      bit mapped;
      bit rep;
      bit acc;
      v = '0;
      if (it.op == OP_WRITE) begin
        tbl_cmd[it.entry_index] = it.code;
        tbl_rep[it.entry_index] = it.entry_repeatable;
        tbl_vld[it.entry_index] = 1'b1;
      end else if (it.protocol != '0) begin
        dt = it.time_ms - last_rx;
        if (dt > TIME_W'(gap_ms)) begin
          last_cmd = it.code;
          last_proto = it.protocol;
          last_fresh = it.time_ms;
          cmd = it.code;
          rep = 1'b0;
          acc = 1'b1;
        end else begin
          mapped = (it.protocol == nec_id) && (last_proto == nec_id) &&
                   (it.code == nec_code) && (dt < NEC_REPEAT_WINDOW_MS);
          cmd = mapped ? last_cmd : it.code;
          rep = mapped || ((it.protocol == last_proto) && (cmd == last_cmd));
          since_fresh = it.time_ms - last_fresh;
          acc = since_fresh > TIME_W'(delay_ms);
        end
        last_rx = it.time_ms;
        v.command = cmd;
        if (acc) begin
          v.accepted = 1'b1;
          v.is_repeat = rep;
          for (int i = 0; i < TABLE_SIZE; i++) begin
            if (!v.matched && tbl_vld[i] && tbl_cmd[i] == cmd) begin
              v.matched = 1'b1;
              v.match_index = IDX_W'(i);
              v.fire = !rep || tbl_rep[i];
            end
          end
        end
      end
      awaited.push_back(v);
    endfunction

    function string show(out_item_t v);
      return $sformatf("acc=%0b rep=%0b cmd=%h hit=%0b idx=%0d fire=%0b",
                       v.accepted, v.is_repeat, v.command, v.matched, v.match_index, v.fire);
    endfunction

    function void compare_result(out_item_t got);
      out_item_t exp;
      bit bad;
      if (awaited.size() == 0) begin
        bad_verdicts++;
        if (bad_verdicts <= 10) $display("unexpected item: %s", show(got));
        return;
      end
      exp = awaited.pop_front();
      bad = (got.accepted !== exp.accepted) || (got.is_repeat !== exp.is_repeat) ||
            (got.command !== exp.command) || (got.matched !== exp.matched) ||
            (got.match_index !== exp.match_index) || (got.fire !== exp.fire);
      if (bad) begin
        bad_verdicts++;
        if (bad_verdicts <= 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected %s", show(exp));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  remote_command_judge judge;
  logic [CMD_W-1:0] cmd_pool[8];
  logic [TIME_W-1:0] now_ms;
  bit calm;
  int items_sent;
  int unsigned cycle_count = 0;

  ir_command_repeat_qualifier_core #(.TABLE_ENTRIES(TABLE_SIZE)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ir_command_repeat_qualifier_core regression: fail");
      $finish;
    end
  end

  function automatic bit stall_roll();
    return !calm && ($urandom_range(0, 99) < 30);
  endfunction

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) judge.compare_result(out_data);
      out_ready <= !stall_roll();
    end
  end

  task automatic push_item(input in_item_t it);
    while (stall_roll()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    judge.take_item(it);
    if (!(it.op == OP_CODE && it.protocol == '0)) items_sent++;
  endtask

  task automatic send_code(input logic [7:0] proto, input logic [31:0] code,
                           input logic [31:0] t);
    in_item_t it;
    it.op = OP_CODE;
    it.protocol = proto;
    it.code = code;
    it.time_ms = t;
    it.entry_index = IDX_W'($urandom);
    it.entry_repeatable = 1'($urandom);
    push_item(it);
  endtask

  task automatic send_entry(input logic [2:0] idx, input logic [31:0] code, input bit rep);
    in_item_t it;
    it.op = OP_WRITE;
    it.protocol = PROTO_W'($urandom);
    it.code = code;
    it.time_ms = $urandom;
    it.entry_index = idx;
    it.entry_repeatable = rep;
    push_item(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (judge.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] gap, input logic [15:0] dly,
                              input logic [7:0] id, input logic [31:0] code);
    cfg_reg_e_t regs[4];
    logic [31:0] vals[4];
    regs[0] = CFG_COMMAND_GAP_MS;
    regs[1] = CFG_REPEAT_DELAY_MS;
    regs[2] = CFG_NEC_PROTOCOL_ID;
    regs[3] = CFG_NEC_REPEAT_CODE;
    vals[0] = {16'($urandom), gap};
    vals[1] = {16'($urandom), dly};
    vals[2] = {24'($urandom), id};
    vals[3] = code;
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      judge.set_reg(regs[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] gap_step(bit fresh);
    logic [31:0] g;
    g = 32'(judge.gap_ms);
    if (fresh) begin
      case ($urandom_range(0, 9))
        0: return g + 1;
        1: return $urandom;
        default: return g + 1 + $urandom_range(0, 400);
      endcase
    end
    case ($urandom_range(0, 9))
      0: return g;
      1: return 32'd0;
      2: return (g >= 300) ? 32'($urandom_range(299, 300)) : g;
      default: return $urandom_range(g / 2, g);
    endcase
  endfunction

  task automatic send_burst();
    logic [7:0] proto;
    logic [7:0] p;
    logic [31:0] cmd;
    logic [31:0] c;
    int n;
    proto = $urandom_range(0, 1) ? judge.nec_id : 8'($urandom_range(1, 255));
    cmd = ($urandom_range(0, 4) != 0) ? cmd_pool[$urandom_range(0, 7)] : $urandom;
    now_ms += gap_step(1'b1);
    send_code(proto, cmd, now_ms);
    n = $urandom_range(1, 12);
    repeat (n) begin
      now_ms += gap_step(1'b0);
      p = proto;
      c = (proto == judge.nec_id && $urandom_range(0, 3) != 0) ? judge.nec_code : cmd;
      case ($urandom_range(0, 11))
        0: c = cmd_pool[$urandom_range(0, 7)];
        1: p = 8'($urandom_range(1, 255));
        2: c = judge.nec_code;
        default: ;
      endcase
      send_code(p, c, now_ms);
    end
  endtask

  initial begin
    int target;
    bit drained;
    judge = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_COMMAND_GAP_MS;
    cfg_data <= '0;
    calm = 1'b0;
    drained = 1'b0;
    items_sent = 0;
    for (int i = 0; i < 8; i++) cmd_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_code(8'd1, 32'h0000_0011, 32'd0);
    send_code(8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_entry(3'd0, 32'h00FF_02FD, 1'b1);
    send_entry(3'd1, 32'h00FF_A857, 1'b0);
    send_entry(3'd7, 32'h00FF_02FD, 1'b0);
    send_entry(3'd3, 32'hFFFF_FFFF, 1'b1);
    send_code(8'd1, 32'h00FF_02FD, 32'd1000);
    send_code(8'd1, 32'hFFFF_FFFF, 32'd1100);
    send_code(8'd1, 32'hFFFF_FFFF, 32'd1250);
    send_code(8'd1, 32'hFFFF_FFFF, 32'd1400);
    send_code(8'd1, 32'hFFFF_FFFF, 32'd1501);
    send_code(8'd255, 32'h00FF_A857, 32'd2000);
    send_code(8'd255, 32'h00FF_A857, 32'd2150);
    send_code(8'd255, 32'h00FF_A857, 32'd2300);
    send_code(8'd255, 32'h00FF_A857, 32'd2450);
    send_code(8'd255, 32'h00FF_A857, 32'd2600);
    send_code(8'd2, 32'h1234_5678, 32'd3000);
    send_code(8'd1, 32'hFFFF_FFFF, 32'd3100);
    send_code(8'd1, 32'hFFFF_FFFF, 32'd3250);
    send_code(8'd1, 32'hFFFF_FFFF, 32'd3400);
    send_code(8'd1, 32'hFFFF_FFFF, 32'd3550);
    send_code(8'd7, 32'h0000_0000, 32'hFFFF_FFF0);
    send_code(8'd7, 32'h0000_0000, 32'h0000_0010);
    send_entry(3'd5, 32'h0000_0000, 1'b1);
    send_code(8'd7, 32'h0000_0000, 32'h0000_1000);

    now_ms = $urandom;
    for (int ph = 0; ph < 9; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: program_regs(16'd0, 16'd0, 8'd255, 32'h0000_0000);
          2: program_regs(16'hFFFF, 16'hFFFF, 8'd1, 32'hFFFF_FFFF);
          default: program_regs(16'($urandom_range(60, 450)), 16'($urandom_range(0, 900)),
                                $urandom_range(0, 1) ? 8'd1 : 8'($urandom_range(1, 255)),
                                $urandom_range(0, 1) ? cmd_pool[$urandom_range(0, 7)] :
                                                       32'($urandom));
        endcase
      end
      calm = (ph == 3);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if (ph == 4 && !drained && items_sent >= target - PHASE_ITEMS / 2) begin
          settle();
          drained = 1'b1;
        end
        case ($urandom_range(0, 99)) inside
          [0:7]: send_entry(3'($urandom),
                            ($urandom_range(0, 4) != 0) ? cmd_pool[$urandom_range(0, 7)] :
                                                          32'($urandom),
                            1'($urandom));
          [8:13]: send_code(8'd0, $urandom, $urandom);
          [14:21]: begin
            if ($urandom_range(0, 3) == 0) now_ms = $urandom;
            else now_ms += gap_step(1'($urandom));
            send_code(8'($urandom_range(1, 255)), $urandom, now_ms);
          end
          default: send_burst();
        endcase
      end
    end
    calm = 1'b0;

    settle();
    if (judge.bad_verdicts == 0 && judge.awaited.size() == 0) begin
      $display("ir_command_repeat_qualifier_core regression: pass");
    end else begin
      $display("ir_command_repeat_qualifier_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/ircrq_pkg.sv
hw/rtl/ircrq_cell.sv
hw/rtl/ir_command_repeat_qualifier_core.sv
hw/rtl/ircrq_checker.sv
sim/tb_top.sv
